// File: rtl/gcpr_pkg.sv
// Package for the gap-cluster point reducer.
// Holds widths, register and mode codes, and the controller/datapath structs.
// No dependencies; every other file of the block uses it.
`timescale 1ns / 1ps

package gcpr_pkg;

    // Data and count widths.
    localparam int DATA_BITS  = 32;
    localparam int COUNT_BITS = 16;
    localparam int SUM_BITS   = DATA_BITS + COUNT_BITS;
    localparam int QCNT_BITS  = $clog2(SUM_BITS);

    // Configuration registers.
    localparam int GAP_BITS      = 31;
    localparam int MODE_BITS     = 2;
    localparam int CFG_DATA_BITS = 31;
    localparam int CFG_IDX_BITS  = 1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_GAP_LIMIT   = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REDUCE_MODE = 1'd1;

    // Reduction modes; codes two and three both select the mean.
    localparam logic [MODE_BITS-1:0] MODE_MIN  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_MAX  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_MEAN = 2'd2;

    // Width of the exact x step and of the gap limit it is compared against.
    localparam int STEP_BITS = (DATA_BITS > GAP_BITS) ? DATA_BITS + 1 : GAP_BITS + 1;

    // A pack closes once it holds this many points.
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic update;
        logic div_start;
        logic push;
        logic run_end;
        logic stream_end;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic gap_close;
        logic count_full;
        logic fin;
        logic mean_mode;
        logic div_done;
        logic out_free;
    } t_dp_status;

endpackage

// File: rtl/gcpr_in_if.sv
// Input point channel of the gap-cluster point reducer.
// Depends on gcpr_pkg for the field widths.
`timescale 1ns / 1ps

interface gcpr_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [gcpr_pkg::DATA_BITS-1:0] point_x;
    logic signed [gcpr_pkg::DATA_BITS-1:0] point_y;
    logic                                 final_point;

    modport source (output valid, output point_x, output point_y, output final_point,
                    input ready);
    modport sink (input valid, input point_x, input point_y, input final_point,
                  output ready);
endinterface

// File: rtl/gcpr_out_if.sv
// Result channel of the gap-cluster point reducer.
// Depends on gcpr_pkg for the field widths.
`timescale 1ns / 1ps

interface gcpr_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [gcpr_pkg::DATA_BITS-1:0] reduced_x;
    logic signed [gcpr_pkg::DATA_BITS-1:0] reduced_y;
    logic                                 run_end;
    logic                                 stream_end;

    modport source (output valid, output reduced_x, output reduced_y, output run_end,
                    output stream_end, input ready);
    modport sink (input valid, input reduced_x, input reduced_y, input run_end,
                  input stream_end, output ready);
endinterface

// File: rtl/gap_cluster_point_reducer.sv
// Gap-cluster point reducer: one point per transaction, one pack at a time.
// Points are taken one at a time: input ready is high only while idle, so a new point waits
// until the last one is through. Mean mode adds the bit-serial 48-bit divisions to each result,
// and a stalled result sink holds the controller until the result register is free.
// Synchronous active-low reset clears configuration, pack and result valid.
`timescale 1ns / 1ps

module gap_cluster_point_reducer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    gcpr_in_if.sink                              i_pt,
    gcpr_out_if.source                           o_res,
    input  logic                                 i_cfg_we,
    input  logic [gcpr_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [gcpr_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    gcpr_pkg::t_dp_cmd    w_cmd;
    gcpr_pkg::t_dp_status w_status;
    logic                 w_in_ready;

    // Sequencing.
    gcpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pt.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    assign i_pt.ready = w_in_ready;

    // Arithmetic and storage.
    gcpr_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_point_x     (i_pt.point_x),
        .i_point_y     (i_pt.point_y),
        .i_final_point (i_pt.final_point),
        .i_out_ready   (o_res.ready),
        .o_out_valid   (o_res.valid),
        .o_reduced_x   (o_res.reduced_x),
        .o_reduced_y   (o_res.reduced_y),
        .o_run_end     (o_res.run_end),
        .o_stream_end  (o_res.stream_end)
    );

endmodule

// File: rtl/gcpr_div.sv
// Signed sum divided by a point count, one quotient bit per cycle, truncating.
// Depends on gcpr_pkg for the sum, count and data widths.
`timescale 1ns / 1ps

module gcpr_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [gcpr_pkg::SUM_BITS-1:0]  i_sum,
    input  logic        [gcpr_pkg::COUNT_BITS-1:0] i_count,
    output logic                                  o_done,
    output logic signed [gcpr_pkg::DATA_BITS-1:0] o_quot
);

    logic [gcpr_pkg::SUM_BITS-1:0]   r_quo;
    logic [gcpr_pkg::COUNT_BITS-1:0] r_rem;
    logic [gcpr_pkg::COUNT_BITS-1:0] r_divisor;
    logic [gcpr_pkg::QCNT_BITS-1:0]  r_cnt;
    logic                            r_busy;
    logic                            r_done;
    logic                            r_neg;

    logic [gcpr_pkg::SUM_BITS-1:0]   w_mag;
    logic [gcpr_pkg::COUNT_BITS:0]   w_shift;
    logic [gcpr_pkg::COUNT_BITS:0]   w_diff;
    logic                            w_bit;
    logic [gcpr_pkg::COUNT_BITS-1:0] n_rem;
    logic [gcpr_pkg::SUM_BITS-1:0]   w_signed_quo;

    // Magnitude of the dividend; the sign is applied to the quotient at the end.
    assign w_mag = i_sum[gcpr_pkg::SUM_BITS-1] ? (~i_sum + 1'b1) : i_sum;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb begin
        w_shift = {r_rem, r_quo[gcpr_pkg::SUM_BITS-1]};
        w_diff  = w_shift - {1'b0, r_divisor};
        w_bit   = (w_shift >= {1'b0, r_divisor});
        n_rem   = w_bit ? w_diff[gcpr_pkg::COUNT_BITS-1:0] : w_shift[gcpr_pkg::COUNT_BITS-1:0];
    end

    // Control of the iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == gcpr_pkg::QCNT_BITS'(gcpr_pkg::SUM_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo     <= w_mag;
            r_rem     <= '0;
            r_divisor <= i_count;
            r_neg     <= i_sum[gcpr_pkg::SUM_BITS-1];
        end else if (r_busy) begin
            r_quo <= {r_quo[gcpr_pkg::SUM_BITS-2:0], w_bit};
            r_rem <= n_rem;
        end
    end

    assign w_signed_quo = r_neg ? (~r_quo + 1'b1) : r_quo;
    assign o_quot       = $signed(w_signed_quo[gcpr_pkg::DATA_BITS-1:0]);
    assign o_done       = r_done;

endmodule

// File: rtl/gcpr_datapath.sv
// Datapath: configuration, input holding register, pack state, two dividers
// for the mean, and the result register. Depends on gcpr_pkg and gcpr_div.
`timescale 1ns / 1ps

module gcpr_datapath (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  gcpr_pkg::t_dp_cmd                         i_cmd,
    output gcpr_pkg::t_dp_status                      o_status,
    input  logic                                      i_cfg_we,
    input  logic        [gcpr_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic        [gcpr_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic signed [gcpr_pkg::DATA_BITS-1:0]     i_point_x,
    input  logic signed [gcpr_pkg::DATA_BITS-1:0]     i_point_y,
    input  logic                                      i_final_point,
    input  logic                                      i_out_ready,
    output logic                                      o_out_valid,
    output logic signed [gcpr_pkg::DATA_BITS-1:0]     o_reduced_x,
    output logic signed [gcpr_pkg::DATA_BITS-1:0]     o_reduced_y,
    output logic                                      o_run_end,
    output logic                                      o_stream_end
);

    localparam int DB = gcpr_pkg::DATA_BITS;
    localparam int CB = gcpr_pkg::COUNT_BITS;
    localparam int SB = gcpr_pkg::SUM_BITS;
    localparam int TB = gcpr_pkg::STEP_BITS;

    logic [gcpr_pkg::GAP_BITS-1:0]  r_gap_limit;
    logic [gcpr_pkg::MODE_BITS-1:0] r_mode;

    logic signed [DB-1:0] r_in_x;
    logic signed [DB-1:0] r_in_y;
    logic                 r_in_fin;

    logic                 r_open;
    logic signed [DB-1:0] r_prev_x;
    logic signed [DB-1:0] r_chosen_x;
    logic signed [DB-1:0] r_chosen_y;
    logic signed [SB-1:0] r_total_x;
    logic signed [SB-1:0] r_total_y;
    logic [CB-1:0]        r_count;

    logic                 r_out_valid;
    logic signed [DB-1:0] r_out_x;
    logic signed [DB-1:0] r_out_y;
    logic                 r_out_run_end;
    logic                 r_out_stream_end;

    logic signed [SB-1:0] w_ext_x;
    logic signed [SB-1:0] w_ext_y;
    logic signed [TB-1:0] w_step;
    logic signed [TB-1:0] w_gap_ext;
    logic                 w_take;
    logic                 w_mean;
    logic                 w_done_x;
    logic                 w_done_y;
    logic signed [DB-1:0] w_mean_x;
    logic signed [DB-1:0] w_mean_y;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_limit <= '0;
            r_mode      <= gcpr_pkg::MODE_MIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gcpr_pkg::CFG_GAP_LIMIT:   r_gap_limit <= i_cfg_data[gcpr_pkg::GAP_BITS-1:0];
                gcpr_pkg::CFG_REDUCE_MODE: r_mode      <= i_cfg_data[gcpr_pkg::MODE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Hold the accepted point for the rest of its processing.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_in_x   <= i_point_x;
            r_in_y   <= i_point_y;
            r_in_fin <= i_final_point;
        end
    end

    // Exact x step against the gap limit, both widened so neither side wraps.
    always_comb begin
        w_ext_x   = {{CB{r_in_x[DB-1]}}, r_in_x};
        w_ext_y   = {{CB{r_in_y[DB-1]}}, r_in_y};
        w_step    = $signed({{(TB-DB){r_in_x[DB-1]}}, r_in_x})
                  - $signed({{(TB-DB){r_prev_x[DB-1]}}, r_prev_x});
        w_gap_ext = $signed({{(TB-gcpr_pkg::GAP_BITS){1'b0}}, r_gap_limit});
        w_mean    = r_mode[1];
    end

    // Minimum or maximum choice under the mode in force for this point.
    always_comb begin
        case (r_mode)
            gcpr_pkg::MODE_MIN: w_take = (r_in_y < r_chosen_y);
            gcpr_pkg::MODE_MAX: w_take = (r_in_y > r_chosen_y);
            default:            w_take = 1'b0;
        endcase
    end

    // Pack state: a push closes and clears the pack, an update adds the point.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open     <= 1'b0;
            r_count    <= '0;
            r_prev_x   <= '0;
            r_chosen_x <= '0;
            r_chosen_y <= '0;
            r_total_x  <= '0;
            r_total_y  <= '0;
        end else if (i_cmd.push) begin
            r_open     <= 1'b0;
            r_count    <= '0;
            r_chosen_x <= '0;
            r_chosen_y <= '0;
            r_total_x  <= '0;
            r_total_y  <= '0;
        end else if (i_cmd.update) begin
            r_prev_x <= r_in_x;
            if (!r_open) begin
                r_open     <= 1'b1;
                r_count    <= CB'(1);
                r_chosen_x <= r_in_x;
                r_chosen_y <= r_in_y;
                r_total_x  <= w_ext_x;
                r_total_y  <= w_ext_y;
            end else begin
                r_count   <= r_count + 1'b1;
                r_total_x <= r_total_x + w_ext_x;
                r_total_y <= r_total_y + w_ext_y;
                if (w_take) begin
                    r_chosen_x <= r_in_x;
                    r_chosen_y <= r_in_y;
                end
            end
        end
    end

    // Mean of x and y, computed side by side.
    gcpr_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_sum   (r_total_x),
        .i_count (r_count),
        .o_done  (w_done_x),
        .o_quot  (w_mean_x)
    );

    gcpr_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_sum   (r_total_y),
        .i_count (r_count),
        .o_done  (w_done_y),
        .o_quot  (w_mean_y)
    );

    // Result register; it frees up when the sink takes the transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_x          <= w_mean ? w_mean_x : r_chosen_x;
            r_out_y          <= w_mean ? w_mean_y : r_chosen_y;
            r_out_run_end    <= i_cmd.run_end;
            r_out_stream_end <= i_cmd.stream_end;
        end
    end

    // Status toward the controller.
    always_comb begin
        o_status.gap_close  = r_open && (w_step > w_gap_ext);
        o_status.count_full = (r_count >= gcpr_pkg::COUNT_MAX);
        o_status.fin        = r_in_fin;
        o_status.mean_mode  = w_mean;
        o_status.div_done   = w_done_x && w_done_y;
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_reduced_x  = r_out_x;
    assign o_reduced_y  = r_out_y;
    assign o_run_end    = r_out_run_end;
    assign o_stream_end = r_out_stream_end;

endmodule

// File: rtl/gcpr_ctrl.sv
// Controller: sequences gap check, pack emission, pack update and flush.
// Depends on gcpr_pkg for the command and status structs.
`timescale 1ns / 1ps

module gcpr_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  gcpr_pkg::t_dp_status i_status,
    output gcpr_pkg::t_dp_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_EMIT   = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_PUSH   = 3'd4;
    localparam logic [2:0] S_UPDATE = 3'd5;
    localparam logic [2:0] S_DECIDE = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    // Low while emitting the pack that a gap closes, high for the close after a final point or full pack.
    logic       r_phase;
    logic       n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state          = r_state;
        n_phase          = r_phase;
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        o_cmd.run_end    = r_phase || !i_status.fin;
        o_cmd.stream_end = r_phase && i_status.fin;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_phase = 1'b0;
                n_state = i_status.gap_close ? S_EMIT : S_UPDATE;
            end
            S_EMIT: begin
                if (i_status.mean_mode) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = r_phase ? S_IDLE : S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_status.fin || i_status.count_full) begin
                    n_phase = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/gcpr_checker.sv
// Port-level assertions for the gap-cluster point reducer, bound to its top level.
// Depends on gcpr_pkg for the data width.
`timescale 1ns / 1ps

module gcpr_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 i_in_ready,
    input logic                                 i_out_valid,
    input logic                                 i_out_ready,
    input logic signed [gcpr_pkg::DATA_BITS-1:0] i_reduced_x,
    input logic signed [gcpr_pkg::DATA_BITS-1:0] i_reduced_y,
    input logic                                 i_run_end,
    input logic                                 i_stream_end
);

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_reduced_x)
            && $stable(i_reduced_y) && $stable(i_run_end) && $stable(i_stream_end)))
        else $error("result transaction changed while stalled");

    // The flush result is always the last one of its point.
    a_stream_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_stream_end) |-> i_run_end)
        else $error("stream end without run end");

    // After reset no result is pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // One point is worked on at a time: accepting one drops ready.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready held after an accepted point");

endmodule

bind gap_cluster_point_reducer gcpr_checker u_gcpr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_pt.valid),
    .i_in_ready   (i_pt.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_reduced_x  (o_res.reduced_x),
    .i_reduced_y  (o_res.reduced_y),
    .i_run_end    (o_res.run_end),
    .i_stream_end (o_res.stream_end)
);
